/* hdl/aggregate_slot_metric_filter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the slot metric filter
// Clocked property checks with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef AGGREGATE_SLOT_METRIC_FILTER_ASSERT_SVH
`define AGGREGATE_SLOT_METRIC_FILTER_ASSERT_SVH

// check on every edge outside reset
`define ASMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on every edge, reset included
`define ASMF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/asmf_pkg.sv */
// ----------------------------------------------------------------------------
// asmf_pkg
// Shared constants, register indexes, metric codes and types.
// ----------------------------------------------------------------------------
`default_nettype none

package asmf_pkg;

    localparam longint unsigned MAX_SLOTS_DEF = 64'd65536;
    localparam int unsigned     FRAC_BITS_DEF = 16;

    localparam int VAL_W     = 64;
    localparam int CNT_W     = 32;
    localparam int POS_W     = 16;
    localparam int ALU_W     = VAL_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd2;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [3:0] {
        MODE_MEAN   = 4'd0,
        MODE_COUNT  = 4'd1,
        MODE_SUM    = 4'd2,
        MODE_MIN    = 4'd3,
        MODE_MAX    = 4'd4,
        MODE_SPREAD = 4'd5,
        MODE_MIDDLE = 4'd6,
        MODE_RANGE  = 4'd7,
        MODE_RAW    = 4'd8
    } asmf_mode_t;

    typedef struct packed {
        logic sub;
        logic cin;
    } asmf_alu_ctl_t;

    typedef struct packed {
        logic [VAL_W-1:0] point_time;
        logic [VAL_W-1:0] point_value;
        logic             empty_mean;
    } asmf_result_t;

endpackage

`default_nettype wire

/* hdl/aggregate_slot_metric_filter.sv */
// ----------------------------------------------------------------------------
// aggregate_slot_metric_filter
// Window filter and metric extraction for ring-archive slots.
// ----------------------------------------------------------------------------
// Slots arrive on the s_ channel, one request per slot, with s_tlast marking
// the last slot of a query; the slot ordinal restarts after it. A slot inside
// the inclusive window yields one point on the m_ channel, in range mode only
// if count and sum are nonzero; others yield none. Registers are written
// through cfg_we / cfg_index / cfg_wdata; the user must write them only while
// idle, as the block does not enforce it. One slot is in work at a time:
// s_tready is high only while the sequencer is idle. Count, sum, min, max,
// raw and an empty mean go from the window test to the output; middle and
// spread first take adder steps. Mean and range run 64 restoring-divider
// passes on the shared 66-bit adder, range after two 32x32 partial products.
// A point waits in the output register while m_tready is low; the next slot
// is taken meanwhile and held in the sequencer until the register frees.
// Reset clears the registers to zero, the ordinal to zero and drops m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module aggregate_slot_metric_filter
#(
    parameter longint unsigned MAX_SLOTS = asmf_pkg::MAX_SLOTS_DEF,
    parameter int unsigned     FRAC_BITS = asmf_pkg::FRAC_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [asmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [asmf_pkg::VAL_W-1:0]     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // slot_time, slot_sum, slot_count, slot_min, slot_max
    input  wire logic [287:0]                   s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // point_position, point_time, point_value
    output logic [143:0]                        m_tdata,
    // empty_mean
    output logic                                m_tuser
);

    localparam int VW = asmf_pkg::VAL_W;
    localparam int CW = asmf_pkg::CNT_W;
    localparam int PW = asmf_pkg::POS_W;
    localparam logic [CW:0] MAX_SLOTS_W = (CW+1)'(MAX_SLOTS);

    logic [VW-1:0] win_start_reg, win_end_reg;
    logic [3:0]    mode_reg;

    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] hold_pos_reg;
    logic [PW:0]   pos_inc;

    logic                   accept;
    logic                   core_idle;
    logic                   res_valid;
    logic                   out_ready;
    asmf_pkg::asmf_result_t res;

    logic           m_tvalid_reg, m_tvalid_next;
    logic [143:0]   m_tdata_reg;
    logic           m_tuser_reg;

    assign accept    = s_tvalid & s_tready;
    assign s_tready  = core_idle;
    assign out_ready = ~m_tvalid_reg | m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg <= '0;
            win_end_reg   <= '0;
            mode_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                asmf_pkg::CFG_WIN_START: win_start_reg <= cfg_wdata;
                asmf_pkg::CFG_WIN_END:   win_end_reg   <= cfg_wdata;
                asmf_pkg::CFG_MODE:      mode_reg      <= cfg_wdata[3:0];
                default:                 mode_reg      <= mode_reg;
            endcase
        end
    end

    // advance the ordinal, wrap at the slot limit, restart after the last slot
    always_comb
    begin
        pos_inc = {1'b0, pos_reg} + (PW+1)'(1);
        if (s_tlast || ({{(CW-PW){1'b0}}, pos_inc} >= MAX_SLOTS_W))
            pos_next = '0;
        else
            pos_next = pos_inc[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (accept)
            pos_reg <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_pos_reg <= pos_reg;
    end

    asmf_core #(.FRAC_BITS(FRAC_BITS)) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .slot_time    (s_tdata[63:0]),
        .slot_sum     (s_tdata[127:64]),
        .slot_count   (s_tdata[159:128]),
        .slot_min     (s_tdata[223:160]),
        .slot_max     (s_tdata[287:224]),
        .window_start (win_start_reg),
        .window_end   (win_end_reg),
        .metric_mode  (mode_reg),
        .out_ready    (out_ready),
        .idle         (core_idle),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_comb
    begin
        if (res_valid && out_ready)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    // hold the point until taken
    always_ff @(posedge clk)
    begin
        if (res_valid && out_ready)
        begin
            m_tdata_reg <= {res.point_value, res.point_time, hold_pos_reg};
            m_tuser_reg <= res.empty_mean;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* hdl/asmf_alu.sv */
// ----------------------------------------------------------------------------
// asmf_alu
// Shared adder and subtractor used by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module asmf_alu
(
    input  wire logic [asmf_pkg::ALU_W-1:0] a,
    input  wire logic [asmf_pkg::ALU_W-1:0] b,
    input  wire asmf_pkg::asmf_alu_ctl_t    ctl,
    output logic      [asmf_pkg::ALU_W-1:0] y
);

    logic [asmf_pkg::ALU_W-1:0] b_op;
    logic                       carry;

    assign b_op  = ctl.sub ? ~b : b;
    assign carry = ctl.sub | ctl.cin;
    assign y     = a + b_op + asmf_pkg::ALU_W'(carry);

endmodule

`default_nettype wire

/* hdl/asmf_core.sv */
// ----------------------------------------------------------------------------
// asmf_core
// Sequencer and datapath registers: window test, metric selection, product
// and restoring division; sums and differences go through the one shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

module asmf_core
#(
    parameter int unsigned FRAC_BITS = asmf_pkg::FRAC_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [asmf_pkg::VAL_W-1:0] slot_time,
    input  wire logic [asmf_pkg::VAL_W-1:0] slot_sum,
    input  wire logic [asmf_pkg::CNT_W-1:0] slot_count,
    input  wire logic [asmf_pkg::VAL_W-1:0] slot_min,
    input  wire logic [asmf_pkg::VAL_W-1:0] slot_max,
    input  wire logic [asmf_pkg::VAL_W-1:0] window_start,
    input  wire logic [asmf_pkg::VAL_W-1:0] window_end,
    input  wire logic [3:0]                 metric_mode,
    input  wire logic                       out_ready,
    output logic                            idle,
    output logic                            res_valid,
    output asmf_pkg::asmf_result_t          res
);

    localparam int VW        = asmf_pkg::VAL_W;
    localparam int CW        = asmf_pkg::CNT_W;
    localparam int AW        = asmf_pkg::ALU_W;
    localparam int PROD_W    = VW + CW;
    localparam int NUM_W     = 2 * VW;
    localparam int DIV_STEPS = VW;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_WIN_LO = 14'b00000000000010,
        ST_WIN_HI = 14'b00000000000100,
        ST_MID    = 14'b00000000001000,
        ST_SPR_A  = 14'b00000000010000,
        ST_SPR_B  = 14'b00000000100000,
        ST_MUL0   = 14'b00000001000000,
        ST_MUL1   = 14'b00000010000000,
        ST_ACC    = 14'b00000100000000,
        ST_NEG    = 14'b00001000000000,
        ST_OVF    = 14'b00010000000000,
        ST_DIV    = 14'b00100000000000,
        ST_SIGN   = 14'b01000000000000,
        ST_OUT    = 14'b10000000000000
    } asmf_state_t;

    asmf_state_t state_reg, state_next;

    logic [VW-1:0]     t_reg, t_next;
    logic [VW-1:0]     sum_reg, sum_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [VW-1:0]     mn_reg, mn_next;
    logic [VW-1:0]     mx_reg, mx_next;
    logic              below_reg, below_next;
    logic              sneg_reg, sneg_next;
    logic              neg_reg, neg_next;
    logic [VW-1:0]     smag_reg, smag_next;
    logic [VW-1:0]     dvsr_reg, dvsr_next;
    logic [VW-1:0]     rem_reg, rem_next;
    logic [VW-1:0]     quo_reg, quo_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [VW-1:0]     prod_reg, prod_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [VW-1:0]     val_reg, val_next;
    logic              empty_reg, empty_next;

    logic [AW-1:0]           alu_a, alu_b, alu_y;
    asmf_pkg::asmf_alu_ctl_t alu_ctl;
    logic                    alu_neg;

    logic [CW-1:0]  mul_a;
    logic [VW-1:0]  mul_p;
    logic [NUM_W-1:0] num;
    logic [VW-1:0]  cnt_sh;
    logic [VW-1:0]  dmag;
    logic [VW:0]    rem2;
    logic           is_range;

    asmf_alu u_alu
    (
        .a   (alu_a),
        .b   (alu_b),
        .ctl (alu_ctl),
        .y   (alu_y)
    );

    assign alu_neg  = alu_y[AW-1];
    assign mul_a    = (state_reg == ST_MUL0) ? smag_reg[CW-1:0] : smag_reg[VW-1:CW];
    assign mul_p    = mul_a * cnt_reg;
    assign num      = {{(NUM_W-PROD_W){1'b0}}, acc_reg} << FRAC_BITS;
    assign cnt_sh   = {{(VW-CW){1'b0}}, cnt_reg} << FRAC_BITS;
    assign dmag     = sum_reg[VW-1] ? alu_y[VW-1:0] : sum_reg;
    assign rem2     = {rem_reg, quo_reg[VW-1]};
    assign is_range = (metric_mode == asmf_pkg::MODE_RANGE);

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_ctl = '{sub: 1'b1, cin: 1'b0};
        case (state_reg)
            ST_WIN_LO:
            begin
                alu_a = {{2{t_reg[VW-1]}}, t_reg};
                alu_b = {{2{window_start[VW-1]}}, window_start};
            end
            ST_WIN_HI:
            begin
                alu_a = {{2{window_end[VW-1]}}, window_end};
                alu_b = {{2{t_reg[VW-1]}}, t_reg};
            end
            ST_MID:
            begin
                alu_a   = {{3{mx_reg[VW-1]}}, mx_reg[VW-1:1]};
                alu_b   = {{3{mn_reg[VW-1]}}, mn_reg[VW-1:1]};
                alu_ctl = '{sub: 1'b0, cin: mx_reg[0] & mn_reg[0]};
            end
            ST_SPR_A:
            begin
                alu_a = {{2{mx_reg[VW-1]}}, mx_reg};
                alu_b = {{2{mn_reg[VW-1]}}, mn_reg};
            end
            ST_SPR_B:
            begin
                alu_a = {{2{mn_reg[VW-1]}}, mn_reg};
                alu_b = {{2{mx_reg[VW-1]}}, mx_reg};
            end
            ST_ACC:
            begin
                alu_a   = {{(AW-(PROD_W-CW)){1'b0}}, acc_reg[PROD_W-1:CW]};
                alu_b   = {2'b00, prod_reg};
                alu_ctl = '{sub: 1'b0, cin: 1'b0};
            end
            ST_NEG:
            begin
                alu_b = {{2{sum_reg[VW-1]}}, sum_reg};
            end
            ST_OVF:
            begin
                alu_a = {2'b00, rem_reg};
                alu_b = {2'b00, dvsr_reg};
            end
            ST_DIV:
            begin
                alu_a = {1'b0, rem2};
                alu_b = {2'b00, dvsr_reg};
            end
            ST_SIGN:
            begin
                alu_b = {2'b00, quo_reg};
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        mn_next    = mn_reg;
        mx_next    = mx_reg;
        below_next = below_reg;
        sneg_next  = sneg_reg;
        neg_next   = neg_reg;
        smag_next  = smag_reg;
        dvsr_next  = dvsr_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        step_next  = step_reg;
        val_next   = val_reg;
        empty_next = empty_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    t_next     = slot_time;
                    sum_next   = slot_sum;
                    cnt_next   = slot_count;
                    mn_next    = slot_min;
                    mx_next    = slot_max;
                    state_next = ST_WIN_LO;
                end
            end
            ST_WIN_LO:
            begin
                below_next = alu_neg;
                state_next = ST_WIN_HI;
            end
            ST_WIN_HI:
            begin
                empty_next = 1'b0;
                if (below_reg || alu_neg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    case (asmf_pkg::asmf_mode_t'(metric_mode))
                        asmf_pkg::MODE_COUNT:
                        begin
                            val_next   = cnt_sh[VW-1] ? asmf_pkg::VAL_MAX : cnt_sh;
                            state_next = ST_OUT;
                        end
                        asmf_pkg::MODE_SUM, asmf_pkg::MODE_RAW:
                        begin
                            val_next   = sum_reg;
                            state_next = ST_OUT;
                        end
                        asmf_pkg::MODE_MIN:
                        begin
                            val_next   = mn_reg;
                            state_next = ST_OUT;
                        end
                        asmf_pkg::MODE_MAX:
                        begin
                            val_next   = mx_reg;
                            state_next = ST_OUT;
                        end
                        asmf_pkg::MODE_SPREAD:
                        begin
                            state_next = ST_SPR_A;
                        end
                        asmf_pkg::MODE_MIDDLE:
                        begin
                            state_next = ST_MID;
                        end
                        asmf_pkg::MODE_RANGE:
                        begin
                            if (cnt_reg == '0 || sum_reg == '0)
                                state_next = ST_IDLE;
                            else
                                state_next = ST_SPR_A;
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                val_next   = '0;
                                empty_next = 1'b1;
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                state_next = ST_NEG;
                            end
                        end
                    endcase
                end
            end
            ST_MID:
            begin
                val_next   = alu_y[VW-1:0];
                state_next = ST_OUT;
            end
            ST_SPR_A:
            begin
                sneg_next  = alu_neg;
                smag_next  = alu_y[VW-1:0];
                state_next = ST_SPR_B;
            end
            ST_SPR_B:
            begin
                smag_next  = sneg_reg ? alu_y[VW-1:0] : smag_reg;
                quo_next   = sneg_reg ? alu_y[VW-1:0] : smag_reg;
                neg_next   = sneg_reg;
                state_next = is_range ? ST_MUL0 : ST_SIGN;
            end
            ST_MUL0:
            begin
                acc_next   = {{(PROD_W-VW){1'b0}}, mul_p};
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                prod_next  = mul_p;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next   = {alu_y[VW-1:0], acc_reg[CW-1:0]};
                state_next = ST_NEG;
            end
            ST_NEG:
            begin
                step_next = '0;
                if (is_range)
                begin
                    dvsr_next  = dmag;
                    neg_next   = sneg_reg ^ sum_reg[VW-1];
                    rem_next   = num[NUM_W-1:VW];
                    quo_next   = num[VW-1:0];
                    state_next = ST_OVF;
                end
                else
                begin
                    dvsr_next  = {{(VW-CW){1'b0}}, cnt_reg};
                    neg_next   = sum_reg[VW-1];
                    rem_next   = '0;
                    quo_next   = dmag;
                    state_next = ST_DIV;
                end
            end
            ST_OVF:
            begin
                if (!alu_neg)
                begin
                    quo_next   = '1;
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = alu_neg ? rem2[VW-1:0] : alu_y[VW-1:0];
                quo_next  = {quo_reg[VW-2:0], ~alu_neg};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                if (neg_reg)
                    val_next = quo_reg[VW-1] ? asmf_pkg::VAL_MIN : alu_y[VW-1:0];
                else
                    val_next = quo_reg[VW-1] ? asmf_pkg::VAL_MAX : quo_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        sum_reg   <= sum_next;
        cnt_reg   <= cnt_next;
        mn_reg    <= mn_next;
        mx_reg    <= mx_next;
        below_reg <= below_next;
        sneg_reg  <= sneg_next;
        neg_reg   <= neg_next;
        smag_reg  <= smag_next;
        dvsr_reg  <= dvsr_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        step_reg  <= step_next;
        val_reg   <= val_next;
        empty_reg <= empty_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res       = '{point_time: t_reg, point_value: val_reg, empty_mean: empty_reg};

endmodule

`default_nettype wire

/* hdl/asmf_checker.sv */
// ----------------------------------------------------------------------------
// asmf_checker
// Port-level checks on the slot metric filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aggregate_slot_metric_filter_assert.svh"

module asmf_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [143:0] m_tdata,
    input wire logic         m_tuser
);

    `ASMF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "point dropped while stalled")
    `ASMF_ASSERT(a_busy, s_tvalid && s_tready |=> !s_tready, "request taken while slot in work")
    `ASMF_ASSERT(a_empty_zero, m_tvalid && m_tuser |-> m_tdata[143:80] == 64'd0, "empty mean not zero")
    `ASMF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "point shown during reset")

endmodule

bind aggregate_slot_metric_filter asmf_checker u_asmf_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot metric filter testbench
// Drives ring-archive slots into the filter under random idling on both
// channels, predicts each point from a mirrored copy of the registers and the
// slot ordinal, and checks every emitted point field by field in order.
// ----------------------------------------------------------------------------

module testbench;

    localparam logic [asmf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 100;
    localparam int PHASES    = 13;
    localparam int PER_PHASE = 95;
    localparam int WRAP_RUN  = 40;

    typedef struct {
        logic signed [63:0] stamp;
        logic signed [63:0] total;
        logic [31:0]        count;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic               last;
    } slot_t;

    typedef struct {
        logic [15:0]        position;
        logic signed [63:0] stamp;
        logic signed [63:0] value;
        logic               empty;
    } point_t;

    class metric_scoreboard;
        logic signed [63:0] win_lo;
        logic signed [63:0] win_hi;
        logic [3:0]         mode;
        logic [15:0]        position;
        point_t             pending_points[$];
        int                 errors;

        function new();
            win_lo   = '0;
            win_hi   = '0;
            mode     = asmf_pkg::MODE_MEAN;
            position = '0;
            errors   = 0;
        endfunction

        function void set_reg(logic [asmf_pkg::CFG_IDX_W-1:0] idx,
                              logic [asmf_pkg::VAL_W-1:0] data);
            case (idx)
                asmf_pkg::CFG_WIN_START: win_lo = data;
                asmf_pkg::CFG_WIN_END:   win_hi = data;
                asmf_pkg::CFG_MODE:      mode = data[3:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] saturate(logic neg, logic [127:0] mag);
            if (neg)
                return (mag >= 128'h8000_0000_0000_0000) ? asmf_pkg::VAL_MIN : -mag[63:0];
            return (mag > 128'(asmf_pkg::VAL_MAX)) ? asmf_pkg::VAL_MAX : mag[63:0];
        endfunction

        function void note_slot(slot_t s);
            point_t       p;
            logic [63:0]  spread_mag;
            logic [63:0]  sum_mag;
            logic         spread_neg;
            logic         sum_neg;
            logic [64:0]  mid;
            logic [127:0] scaled;
            p.position = position;
            p.stamp    = s.stamp;
            p.value    = '0;
            p.empty    = 1'b0;
            position   = s.last ? 16'd0 : position + 16'd1;
            if (s.stamp < win_lo || s.stamp > win_hi)
                return;
            spread_neg = s.hi < s.lo;
            spread_mag = spread_neg ? s.lo - s.hi : s.hi - s.lo;
            sum_neg    = s.total[63];
            sum_mag    = sum_neg ? -s.total : s.total;
            case (mode)
                asmf_pkg::MODE_COUNT:
                    p.value = 64'(s.count) << asmf_pkg::FRAC_BITS_DEF;
                asmf_pkg::MODE_SUM, asmf_pkg::MODE_RAW:
                    p.value = s.total;
                asmf_pkg::MODE_MIN:
                    p.value = s.lo;
                asmf_pkg::MODE_MAX:
                    p.value = s.hi;
                asmf_pkg::MODE_SPREAD:
                    p.value = saturate(spread_neg, 128'(spread_mag));
                asmf_pkg::MODE_MIDDLE:
                begin
                    mid     = {s.hi[63], s.hi} + {s.lo[63], s.lo};
                    p.value = mid[64:1];
                end
                asmf_pkg::MODE_RANGE:
                begin
                    if (s.count == 0 || s.total == 0)
                        return;
                    scaled  = (128'(spread_mag) * 128'(s.count)) << asmf_pkg::FRAC_BITS_DEF;
                    p.value = saturate(spread_neg ^ sum_neg, scaled / 128'(sum_mag));
                end
                default:
                begin
                    if (s.count == 0)
                        p.empty = 1'b1;
                    else
                        p.value = saturate(sum_neg, 128'(sum_mag) / 128'(s.count));
                end
            endcase
            pending_points.push_back(p);
        endfunction

        task report(string what);
            $display("%0t ns  mismatch: %s", $time, what);
            errors++;
        endtask

        task check_point(logic [143:0] data, logic flag);
            point_t p;
            if (pending_points.size() == 0)
            begin
                report($sformatf("unexpected point at position %0d", data[15:0]));
                return;
            end
            p = pending_points.pop_front();
            if (data[15:0] !== p.position)
                report($sformatf("position %0d, want %0d", data[15:0], p.position));
            if (data[79:16] !== p.stamp)
                report($sformatf("time %0d, want %0d", $signed(data[79:16]), p.stamp));
            if (data[143:80] !== p.value)
                report($sformatf("value %0d, want %0d at position %0d",
                                 $signed(data[143:80]), p.value, p.position));
            if (flag !== p.empty)
                report($sformatf("empty_mean %b, want %b at position %0d",
                                 flag, p.empty, p.position));
        endtask
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [asmf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [asmf_pkg::VAL_W-1:0]     cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic [287:0]                   s_tdata   = '0;
    logic                           s_tlast   = 1'b0;
    logic                           m_tready  = 1'b0;
    logic                           s_tready;
    logic                           m_tvalid;
    logic [143:0]                   m_tdata;
    logic                           m_tuser;

    bit sender_idle;
    bit receiver_idle;
    bit hold_request;

    metric_scoreboard board = new();

    aggregate_slot_metric_filter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = receiver_idle ? $urandom_range(0, 13) : 0;
            if (hold_request)
            begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            board.check_point(m_tdata, m_tuser);
        end
    end

    task automatic send_slot(input slot_t s);
        int gap;
        gap = sender_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s.hi, s.lo, s.count, s.total, s.stamp};
        s_tlast  <= s.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_slot(s);
    endtask

    task automatic wait_points();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_points.size() != 0);
    endtask

    task automatic drain_points();
        wait_points();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [asmf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [asmf_pkg::VAL_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, data);
    endtask

    task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [63:0] mode_word);
        drain_points();
        write_reg(asmf_pkg::CFG_WIN_START, lo);
        write_reg(asmf_pkg::CFG_WIN_END, hi);
        write_reg(asmf_pkg::CFG_MODE, mode_word);
    endtask

    function automatic slot_t make_slot(logic [63:0] stamp, logic [63:0] total,
                                        logic [31:0] count, logic [63:0] lo,
                                        logic [63:0] hi, logic last);
        slot_t s;
        s.stamp = stamp;
        s.total = total;
        s.count = count;
        s.lo    = lo;
        s.hi    = hi;
        s.last  = last;
        return s;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] w;
        w = rand_word();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 64'd1;
            2:       return '1;
            3:       return asmf_pkg::VAL_MIN;
            4:       return asmf_pkg::VAL_MAX;
            5:       return {{44{w[19]}}, w[19:0]};
            6:       return {{24{w[39]}}, w[39:0]};
            default: return w;
        endcase
    endfunction

    function automatic logic [31:0] rand_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3, 4:    return $urandom_range(1, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic slot_t random_slot();
        slot_t       s;
        logic [63:0] span;
        logic [63:0] tmp;
        s.total = rand_value();
        s.count = rand_count();
        s.lo    = rand_value();
        s.hi    = rand_value();
        // keep min at or below max for most slots
        if ($urandom_range(0, 4) != 0 && s.hi < s.lo)
        begin
            tmp  = s.lo;
            s.lo = s.hi;
            s.hi = tmp;
        end
        span = board.win_hi - board.win_lo;
        case ($urandom_range(0, 9))
            0:       s.stamp = board.win_lo;
            1:       s.stamp = board.win_hi;
            2:       s.stamp = board.win_lo - 1;
            3:       s.stamp = board.win_hi + 1;
            4:       s.stamp = rand_word();
            default: s.stamp = (board.win_hi < board.win_lo || span == '1) ? rand_word()
                               : board.win_lo + rand_word() % (span + 64'd1);
        endcase
        s.last = ($urandom_range(0, 15) == 0);
        return s;
    endfunction

    initial
    begin
        int          phase;
        int          n;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] w;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle   = 1'b1;
        receiver_idle = 1'b1;

        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 64'(asmf_pkg::MODE_MEAN));
        send_slot(make_slot(0, 5, 0, 0, 0, 1'b0));
        send_slot(make_slot(1, asmf_pkg::VAL_MIN, 1, 0, 0, 1'b0));
        send_slot(make_slot(2, -64'sd7, 2, 0, 0, 1'b0));
        send_slot(make_slot(asmf_pkg::VAL_MAX, asmf_pkg::VAL_MAX, '1, 0, 0, 1'b0));
        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 64'(asmf_pkg::MODE_COUNT));
        send_slot(make_slot(asmf_pkg::VAL_MIN, 0, '1, 0, 0, 1'b0));
        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 64'(asmf_pkg::MODE_SUM));
        send_slot(make_slot(3, asmf_pkg::VAL_MIN, 3, 0, 0, 1'b0));
        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 64'(asmf_pkg::MODE_MIN));
        send_slot(make_slot(4, 0, 3, asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 1'b0));
        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 64'(asmf_pkg::MODE_MAX));
        send_slot(make_slot(5, 0, 3, asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 1'b0));
        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 64'(asmf_pkg::MODE_SPREAD));
        send_slot(make_slot(6, 0, 3, asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 1'b0));
        send_slot(make_slot(7, 0, 3, asmf_pkg::VAL_MAX, asmf_pkg::VAL_MIN, 1'b0));
        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 64'(asmf_pkg::MODE_MIDDLE));
        send_slot(make_slot(8, 0, 3, asmf_pkg::VAL_MAX, asmf_pkg::VAL_MAX, 1'b0));
        send_slot(make_slot(9, 0, 3, asmf_pkg::VAL_MIN, asmf_pkg::VAL_MIN, 1'b0));
        send_slot(make_slot(10, 0, 3, '1, 0, 1'b0));
        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 64'(asmf_pkg::MODE_RANGE));
        send_slot(make_slot(11, 8, 0, 0, 100, 1'b0));
        send_slot(make_slot(12, 0, 4, 0, 100, 1'b0));
        send_slot(make_slot(13, 1, '1, asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 1'b0));
        send_slot(make_slot(14, -64'sd3, 5, 0, 64'd100 << 16, 1'b0));
        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 64'(asmf_pkg::MODE_RAW));
        send_slot(make_slot(15, '1, 0, 0, 0, 1'b0));
        // unused mode codes, upper data bits set: mean
        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, 64'hFFFF_FFFF_FFFF_FFF9);
        send_slot(make_slot(16, 9, 0, 0, 0, 1'b0));
        configure(asmf_pkg::VAL_MIN, asmf_pkg::VAL_MAX, '1);
        write_reg(CFG_SPARE, 64'(asmf_pkg::MODE_SUM));
        send_slot(make_slot(17, 10, 3, 0, 0, 1'b0));
        configure(5, 4, 64'(asmf_pkg::MODE_SUM));
        send_slot(make_slot(4, 1, 1, 0, 0, 1'b0));
        send_slot(make_slot(5, 1, 1, 0, 0, 1'b0));
        configure(5, 5, 64'(asmf_pkg::MODE_SUM));
        send_slot(make_slot(5, 2, 1, 0, 0, 1'b0));
        send_slot(make_slot(6, 2, 1, 0, 0, 1'b0));
        send_slot(make_slot(4, 2, 1, 0, 0, 1'b1));

        // run slots back to back with no idling
        configure(1000, 1000, 64'(asmf_pkg::MODE_SUM));
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        for (n = 0; n < WRAP_RUN; n++)
            send_slot(make_slot(n >= WRAP_RUN - 5 ? 1000 : 0, n, 1, 0, 0, n == WRAP_RUN - 1));

        for (phase = 0; phase < PHASES; phase++)
        begin
            w = rand_word();
            case (phase % 7)
                0:
                begin
                    lo = asmf_pkg::VAL_MIN;
                    hi = asmf_pkg::VAL_MAX;
                end
                1:
                begin
                    lo = '0;
                    hi = '0;
                end
                2:
                begin
                    lo = w | 64'd1;
                    hi = lo - 64'd1;
                end
                3:
                begin
                    lo = w;
                    hi = ($signed(w) > $signed(asmf_pkg::VAL_MAX - 64'd64)) ?
                         asmf_pkg::VAL_MAX : w + 64'd64;
                end
                4:
                begin
                    lo = asmf_pkg::VAL_MIN;
                    hi = w;
                end
                5:
                begin
                    lo = w;
                    hi = asmf_pkg::VAL_MAX;
                end
                default:
                begin
                    lo = {{8{w[55]}}, w[55:0]};
                    hi = lo + {8'd0, rand_word() >> 8};
                end
            endcase
            w      = rand_word();
            w[3:0] = 4'(phase);
            configure(lo, hi, w);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_SPARE, rand_word());
            sender_idle   = (phase % 3 != 2);
            receiver_idle = (phase % 4 != 3);
            for (n = 0; n < PER_PHASE; n++)
            begin
                if (phase == 4 && n == 30)
                    hold_request = 1'b1;
                if (phase == 6 && n == 50)
                    wait_points();
                send_slot(random_slot());
            end
        end

        drain_points();
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
